/* rtl/sha256_pkg.sv */
// SHA-256 byte hasher package: types, constants and round functions.
// No dependencies.
package sha256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds     = 64;
	localparam int unsigned QueueDepth = 4;
	localparam logic [7:0]  PadMark    = 8'h80;
	localparam logic [5:0]  LengthOfs  = 6'd56;

	typedef logic [31:0] word_t;

	// Command from the front part to the back part.
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
	} cmd_t;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

/* rtl/sha256_stream_if.sv */
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing; payload type set by parameter.
interface sha256_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte stream hasher.
// Depends on sha256_pkg, sha256_stream_if, sha256_front, sha256_core.
//
//  channel  dir  payload                                   transaction
//  in       in   message_byte[8] has_byte end_of_message   one message byte or end mark
//  out      out  digest_word[32] word_index[3] last_word   one digest word
//
// A full block is loaded word by word into the schedule window, then runs 64 rounds
// (one per cycle, set by the single round unit) and a final update of the hash.
// The end of a message pads one byte per cycle and runs one or two more blocks.
// The input queue keeps taking bytes while the core compresses, up to its depth.
// Reset sets the initial hash values and clears all counts; out stalls hold the word.
module sha256_byte_stream_hasher #(
	parameter int unsigned QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
	input logic clk,
	input logic arst_n,
	sha256_stream_if.sink   in_ch,
	sha256_stream_if.source out_ch
);
	logic             cmd_valid, cmd_ready;
	sha256_pkg::cmd_t cmd;

	sha256_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n,
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_data  (in_ch.data),
		.cmd_valid, .cmd_ready, .cmd
	);

	sha256_core u_core (
		.clk, .arst_n,
		.cmd_valid, .cmd_ready, .cmd,
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data)
	);
endmodule

/* rtl/sha256_front.sv */
// Front part: classifies input items and queues commands for the core.
// Depends on sha256_pkg.
module sha256_front #(
	parameter int unsigned DEPTH = sha256_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha256_pkg::in_item_t in_data,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output sha256_pkg::cmd_t    cmd
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sha256_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;
	logic push, pop, useful;

	// Idle items (no byte, no end) are dropped here.
	assign useful    = in_data.has_byte | in_data.end_of_message;
	assign in_ready  = (count_q != (AW+1)'(DEPTH));
	assign push      = in_valid & in_ready & useful;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid & cmd_ready;
	assign cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data: in_data.message_byte, has_byte: in_data.has_byte,
				eom: in_data.end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= (AW+1)'(DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (count_q == '0) |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !useful) |=> (count_q == $past(count_q) - (AW+1)'($past(pop))))
		else $error("idle item entered queue");
endmodule

/* rtl/sha256_core.sv */
// Back part: block buffer, padding, 64-round compression and digest output.
// Depends on sha256_pkg.
module sha256_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  sha256_pkg::cmd_t     cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sha256_pkg::out_item_t out_data
);
	typedef enum logic [2:0] {
		ST_ACCEPT, ST_PAD, ST_LOAD, ST_ROUND, ST_FINAL, ST_EMIT
	} state_t;

	state_t state_q;
	logic [31:0] buf_q [16]; // block buffer, big-endian bytes within each word
	logic [5:0]  byte_cnt_q;
	logic [63:0] bit_cnt_q;
	sha256_pkg::word_t hash_q [8];
	sha256_pkg::word_t w_q [16];
	sha256_pkg::word_t v_q [8];
	logic [5:0]  round_q;
	logic [3:0]  ld_q;      // load counter, one schedule word per cycle
	logic        eom_q;     // message end pending
	logic        len_done_q; // length goes into this block, this is the final block
	logic        mark_done_q;
	logic [2:0]  emit_q;
	logic        out_valid_q;

	sha256_pkg::word_t wt, t1, t2, a, e, s0w, s1w;

	always_comb begin
		a  = v_q[0];
		e  = v_q[4];
		s1w = sha256_pkg::small_sigma1(w_q[14]);
		s0w = sha256_pkg::small_sigma0(w_q[1]);
		// Window kept as a shift line: w_q[0] is the oldest word.
		wt = (round_q < 6'd16) ? w_q[0] : (s1w + w_q[9] + s0w + w_q[0]);
		t1 = v_q[7] + sha256_pkg::big_sigma1(e) + ((e & v_q[5]) ^ (~e & v_q[6]))
			+ sha256_pkg::RoundK[round_q] + wt;
		t2 = sha256_pkg::big_sigma0(a) + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// Shift line feeds itself: for r<16 the word rotates, later the new word enters.
	assign cmd_ready = (state_q == ST_ACCEPT) && !eom_q;
	assign out_valid = out_valid_q;
	assign out_data  = '{digest_word: hash_q[emit_q], word_index: emit_q,
		last_word: (emit_q == 3'd7)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCEPT;
			byte_cnt_q  <= '0;
			bit_cnt_q   <= '0;
			round_q     <= '0;
			ld_q        <= '0;
			eom_q       <= 1'b0;
			len_done_q  <= 1'b0;
			mark_done_q <= 1'b0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::InitHash[i];
		end else begin
			unique case (state_q)
				ST_ACCEPT: begin
					if (cmd_valid) begin
						if (cmd.has_byte) begin
							buf_q[byte_cnt_q[5:2]][{~byte_cnt_q[1:0], 3'd0} +: 8] <= cmd.data;
							byte_cnt_q <= byte_cnt_q + 1'b1;
							bit_cnt_q  <= bit_cnt_q + 64'd8;
						end
						eom_q <= cmd.eom;
						if (cmd.has_byte && byte_cnt_q == 6'd63) begin
							state_q <= ST_LOAD;
							ld_q    <= '0;
						end else if (cmd.eom) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// One byte a cycle: mark, zeros, then length at 56..63 in the final block.
					if (!mark_done_q) begin
						buf_q[byte_cnt_q[5:2]][{~byte_cnt_q[1:0], 3'd0} +: 8] <=
							sha256_pkg::PadMark;
						mark_done_q <= 1'b1;
						if (byte_cnt_q < sha256_pkg::LengthOfs) len_done_q <= 1'b1;
					end else if (byte_cnt_q >= sha256_pkg::LengthOfs && len_done_q) begin
						buf_q[byte_cnt_q[5:2]][{~byte_cnt_q[1:0], 3'd0} +: 8] <=
							bit_cnt_q[{3'd7 - byte_cnt_q[2:0], 3'd0} +: 8];
					end else begin
						buf_q[byte_cnt_q[5:2]][{~byte_cnt_q[1:0], 3'd0} +: 8] <= 8'h00;
					end
					if (byte_cnt_q == 6'd63) begin
						state_q <= ST_LOAD;
						ld_q    <= '0;
					end
					byte_cnt_q <= byte_cnt_q + 1'b1;
				end
				ST_LOAD: begin
					w_q[ld_q] <= buf_q[ld_q];
					if (ld_q == 4'd15) begin
						state_q <= ST_ROUND;
						round_q <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
					end
					ld_q <= ld_q + 1'b1;
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wt;
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= e;
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= a;
					v_q[0] <= t1 + t2;
					round_q <= round_q + 1'b1;
					if (round_q == 6'd63) state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					byte_cnt_q <= '0;
					if (!eom_q) begin
						state_q <= ST_ACCEPT;
					end else if (len_done_q) begin
						state_q     <= ST_EMIT;
						emit_q      <= '0;
						out_valid_q <= 1'b1;
					end else begin
						// Next block always has room for the length.
						state_q    <= ST_PAD;
						len_done_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						emit_q <= emit_q + 1'b1;
						if (emit_q == 3'd7) begin
							out_valid_q <= 1'b0;
							state_q     <= ST_ACCEPT;
							eom_q       <= 1'b0;
							len_done_q  <= 1'b0;
							bit_cnt_q   <= '0;
							mark_done_q <= 1'b0;
							for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::InitHash[i];
						end
					end
				end
				default: state_q <= ST_ACCEPT;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_EMIT))
		else $error("digest shown outside emit");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == 6'd63) |=> (state_q == ST_FINAL))
		else $error("round count lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(emit_q))
		else $error("digest index moved while stalled");
endmodule

/* tb/sha256_hasher_checker.sv */
// Watches both channels of the SHA-256 hasher, predicts the digest words and compares them.
// Depends on sha256_pkg and sha256_stream_if.
module sha256_hasher_checker (
	input logic clk,
	input logic arst_n,
	sha256_stream_if in_mon,
	sha256_stream_if out_mon,
	output int errors,
	output int pending,
	output int digests
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  blk [64];
	int          fill;
	logic [63:0] bit_len;
	sha256_pkg::word_t     hv [8];
	sha256_pkg::out_item_t digest_q [$];

	function automatic sha256_pkg::word_t ror(sha256_pkg::word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		sha256_pkg::word_t w [16];
		sha256_pkg::word_t v [8];
		sha256_pkg::word_t t1, t2, nw;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 0; i < 8; i++)
			v[i] = hv[i];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				nw = w[r];
			end else begin
				nw = (ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10))
					+ w[(r-7)&15]
					+ (ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3))
					+ w[r&15];
				w[r&15] = nw;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[r] + nw;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hv[i] += v[i];
	endtask

	task automatic restart();
		for (int i = 0; i < 8; i++)
			hv[i] = sha256_pkg::InitHash[i];
		fill = 0;
		bit_len = '0;
	endtask

	task automatic absorb(sha256_pkg::in_item_t it);
		int idx;
		sha256_pkg::out_item_t o;
		if (it.has_byte) begin
			blk[fill] = it.message_byte;
			fill++;
			bit_len += 64'd8;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		end
		if (!it.end_of_message)
			return;
		idx = fill;
		blk[idx++] = sha256_pkg::PadMark;
		if (idx > sha256_pkg::LengthOfs) begin
			while (idx < 64)
				blk[idx++] = 8'h00;
			compress();
			idx = 0;
		end
		while (idx < sha256_pkg::LengthOfs)
			blk[idx++] = 8'h00;
		for (int i = 0; i < 8; i++)
			blk[sha256_pkg::LengthOfs + i] = bit_len[63 - 8*i -: 8];
		compress();
		for (int i = 0; i < 8; i++) begin
			o.digest_word = hv[i];
			o.word_index  = 3'(i);
			o.last_word   = (i == 7);
			digest_q.push_back(o);
		end
		digests++;
		restart();
	endtask

	initial begin
		errors = 0;
		digests = 0;
		restart();
	end

	assign pending = digest_q.size();

	always @(posedge clk) begin
		sha256_pkg::out_item_t got, want;
		if (arst_n) begin
			if (in_mon.valid && in_mon.ready)
				absorb(in_mon.data);
			if (out_mon.valid && out_mon.ready) begin
				got = out_mon.data;
				if (digest_q.size() == 0) begin
					$error("unexpected digest word %h", got.digest_word);
					errors++;
				end else begin
					want = digest_q.pop_front();
					if (got.digest_word !== want.digest_word) begin
						$error("digest_word expected %h actual %h", want.digest_word,
							got.digest_word);
						errors++;
					end
					if (got.word_index !== want.word_index) begin
						$error("word_index expected %0d actual %0d", want.word_index,
							got.word_index);
						errors++;
					end
					if (got.last_word !== want.last_word) begin
						$error("last_word expected %0d actual %0d", want.last_word,
							got.last_word);
						errors++;
					end
				end
			end
		end
	end
endmodule

/* tb/sha256_byte_stream_hasher_tb.sv */
// Stimulus and verdict for the SHA-256 byte stream hasher.
// Depends on sha256_pkg, sha256_stream_if, the hasher and sha256_hasher_checker.
module sha256_byte_stream_hasher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, pending, digests;
	int   sent = 0;
	int   long_hold = 0;

	sha256_stream_if #(.payload_t(sha256_pkg::in_item_t))  in_ch ();
	sha256_stream_if #(.payload_t(sha256_pkg::out_item_t)) out_ch ();

	sha256_byte_stream_hasher dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	sha256_hasher_checker chk (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.errors(errors), .pending(pending), .digests(digests)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	task automatic send(logic [7:0] b, logic hb, logic eom);
		int gap;
		gap = $urandom_range(0, 3);
		if (sent % 40 > 30)
			gap = 0;
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= '{message_byte: b, has_byte: hb, end_of_message: eom};
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// one message of len bytes, an occasional idle item inside, end bare or with the last byte
	task automatic send_msg(int len, bit bare_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send(8'($urandom), 1'b0, 1'b0);
			send(8'($urandom), 1'b1, !bare_end && i == len - 1);
		end
		if (bare_end || len == 0)
			send(8'($urandom), 1'b0, 1'b1);
	endtask

	// receiver: random stalls, plus one long hold-off while the sender keeps pushing
	initial begin
		int st;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold == 1) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
				long_hold = 2;
			end
			st = $urandom_range(0, 3);
			if (digests % 4 == 3)
				st = 0;
			if (st != 0) begin
				out_ch.ready <= 1'b0;
				repeat (st - 1) @(negedge clk);
				@(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// directed: empty message, one byte, extremes, padding boundaries
		send(8'h00, 1'b0, 1'b1);
		send(8'hff, 1'b1, 1'b1);
		send(8'h00, 1'b1, 1'b0);
		send(8'h5a, 1'b0, 1'b0);
		send(8'hff, 1'b1, 1'b0);
		send(8'h00, 1'b0, 1'b1);
		send_msg(55, 1'b0);
		send_msg(56, 1'b1);
		long_hold = 1;
		send_msg(64, 1'b0);
		send_msg(63, 1'b1);
		send_msg(3, 1'b0);
		send_msg(3, 1'b0);
		send_msg(0, 1'b1);
		while (sent < 230)
			send_msg($urandom_range(0, 12), $urandom_range(0, 1));
		in_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		$display("Hashed %0d messages from %0d input transactions, empty through multi-block,",
			digests, sent);
		$display("with bare and byte-carrying end marks and a long output hold-off.");
		if (errors == 0)
			$display("sha256_byte_stream_hasher: match");
		else
			$display("sha256_byte_stream_hasher: mismatch");
		$finish;
	end

	initial begin
		#3ms;
		$display("sha256_byte_stream_hasher: mismatch");
		$finish;
	end
endmodule
